// File: hdl/mrfr_pkg.sv
// shared types, codes and crc helper for the modbus rtu frame receiver
package mrfr_pkg;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } mrfr_req_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_REJECT   = 3'd2,
    EV_DROP     = 3'd3,
    EV_TOO_LONG = 3'd4,
    EV_DONE     = 3'd5
  } mrfr_event_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 1'b1;

  // modbus constants
  localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'h10;
  localparam logic [7:0]  ADDR_BROADCAST    = 8'h00;
  localparam logic [8:0]  LEN_FIXED         = 9'd8;
  localparam logic [8:0]  LEN_WM_BASE       = 9'd9;
  localparam logic [8:0]  CNT_FUNC_DONE     = 9'd2;
  localparam logic [8:0]  CNT_BYTE_COUNT    = 9'd7;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  typedef struct packed {
    mrfr_req_t   req_type;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
    logic [7:0]  read_index;
  } mrfr_in_t;

  typedef struct packed {
    mrfr_event_t event_res;
    logic        gap_restart;
    logic        frame_ready;
    logic [8:0]  frame_length;
    logic [7:0]  read_data;
  } mrfr_out_t;

  // queue word: result plus flag telling whether read_data is valid store data
  typedef struct packed {
    mrfr_out_t res;
    logic      rd_hit;
  } mrfr_entry_t;

  // free space seen by the front
  typedef struct packed {
    logic room_one;
    logic room_two;
  } mrfr_q_room_t;

  // one byte through the reflected crc-16/modbus register
  function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/mrfr_front.sv
// front end: accepts words, runs the frame state, crc and frame store
module mrfr_front #(
  parameter int FRAME_MAX = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mrfr_pkg::mrfr_in_t                 in_data,
  input  logic                               cfg_we,
  input  logic [mrfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrfr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  mrfr_pkg::mrfr_q_room_t             q_room,
  output logic                               q_push,
  output mrfr_pkg::mrfr_entry_t              q_entry
);

  localparam int STORE_DEPTH = 2 * FRAME_MAX;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam logic [8:0] FRAME_MAX_C = 9'(FRAME_MAX);
  localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(FRAME_MAX);

  // configuration
  logic [7:0]  slave_addr_r;
  logic [15:0] gap_timeout_r;

  // frame state
  logic [8:0]  rx_count_r, rx_count_nxt;
  logic [8:0]  expected_r, expected_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        bank_r, bank_nxt;
  logic        held_r, held_nxt;
  logic [8:0]  held_len_r, held_len_nxt;
  logic [15:0] crc_run_r, crc_run_nxt;
  logic [15:0] crc_h0_r, crc_h0_nxt;
  logic [15:0] crc_h1_r, crc_h1_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic [7:0]  hdr1_r, hdr1_nxt;
  logic [7:0]  prev_byte_r, prev_byte_nxt;

  // result stage
  logic                    s1_valid_r;
  mrfr_pkg::mrfr_out_t     s1_res_r;
  logic                    s1_rd_hit_r;

  // frame store, two banks of FRAME_MAX bytes
  logic [7:0]        store [STORE_DEPTH];
  logic [7:0]        store_q_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic                accept;
  mrfr_pkg::mrfr_out_t res;
  logic                rd_hit;

  assign in_stall = s1_valid_r ? !q_room.room_two : !q_room.room_one;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [8:0]  cnt_eff;
    logic [8:0]  exp_eff;
    logic [8:0]  cnt_new;
    logic [8:0]  exp_new;
    logic [15:0] run_base;
    logic [15:0] h0_base;
    logic [7:0]  hdr0_new;
    logic [7:0]  hdr1_new;
    logic        addr_ok;
    logic        wm_len;

    rx_count_nxt  = rx_count_r;
    expected_nxt  = expected_r;
    last_time_nxt = last_time_r;
    bank_nxt      = bank_r;
    held_nxt      = held_r;
    held_len_nxt  = held_len_r;
    crc_run_nxt   = crc_run_r;
    crc_h0_nxt    = crc_h0_r;
    crc_h1_nxt    = crc_h1_r;
    hdr0_nxt      = hdr0_r;
    hdr1_nxt      = hdr1_r;
    prev_byte_nxt = prev_byte_r;

    cnt_eff  = rx_count_r;
    exp_eff  = expected_r;
    cnt_new  = rx_count_r;
    exp_new  = expected_r;
    run_base = crc_run_r;
    h0_base  = crc_h0_r;
    hdr0_new = hdr0_r;
    hdr1_new = hdr1_r;
    addr_ok  = 1'b0;
    wm_len   = 1'b0;

    wr_en   = 1'b0;
    wr_addr = ADDR_W'(rx_count_r) + (bank_r ? BANK_OFS : '0);
    rd_addr = ADDR_W'(in_data.read_index) + (bank_r ? '0 : BANK_OFS);
    rd_hit  = 1'b0;

    res.event_res   = mrfr_pkg::EV_NONE;
    res.gap_restart = 1'b0;
    res.read_data   = '0;

    if (accept) begin
      case (in_data.req_type)
        mrfr_pkg::REQ_BYTE: begin
          // gap timeout on a partial frame, tick difference wraps
          if (rx_count_r != 9'd0 &&
              (in_data.time_ms - last_time_r) > {16'd0, gap_timeout_r}) begin
            cnt_eff         = '0;
            exp_eff         = '0;
            res.gap_restart = 1'b1;
          end
          rx_count_nxt  = cnt_eff;
          expected_nxt  = exp_eff;
          last_time_nxt = in_data.time_ms;
          if (held_r || cnt_eff >= FRAME_MAX_C) begin
            rx_count_nxt  = '0;
            expected_nxt  = '0;
            res.event_res = mrfr_pkg::EV_DROP;
          end else begin
            run_base = (cnt_eff == 9'd0) ? mrfr_pkg::CRC_INIT : crc_run_r;
            h0_base  = (cnt_eff == 9'd0) ? mrfr_pkg::CRC_INIT : crc_h0_r;
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(cnt_eff) + (bank_r ? BANK_OFS : '0);
            hdr0_new = (cnt_eff == 9'd0) ? in_data.rx_byte : hdr0_r;
            hdr1_new = (cnt_eff == 9'd1) ? in_data.rx_byte : hdr1_r;
            hdr0_nxt = hdr0_new;
            hdr1_nxt = hdr1_new;
            crc_h1_nxt  = h0_base;
            crc_h0_nxt  = run_base;
            crc_run_nxt = mrfr_pkg::crc_absorb(run_base, in_data.rx_byte);
            cnt_new = cnt_eff + 9'd1;
            exp_new = exp_eff;
            if (cnt_new == mrfr_pkg::CNT_FUNC_DONE) begin
              exp_new = (hdr1_new == mrfr_pkg::FC_WRITE_MULTIPLE) ? 9'd0 : mrfr_pkg::LEN_FIXED;
            end
            // byte count of a write-multiple request sets the length
            wm_len = (cnt_new == mrfr_pkg::CNT_BYTE_COUNT) &&
                     (hdr1_new == mrfr_pkg::FC_WRITE_MULTIPLE);
            if (wm_len) begin
              exp_new = mrfr_pkg::LEN_WM_BASE + 9'(in_data.rx_byte);
            end
            addr_ok = (hdr0_new == slave_addr_r) || (hdr0_new == mrfr_pkg::ADDR_BROADCAST);
            prev_byte_nxt = in_data.rx_byte;
            rx_count_nxt  = cnt_new;
            expected_nxt  = exp_new;
            if (wm_len && exp_new > FRAME_MAX_C) begin
              rx_count_nxt  = '0;
              expected_nxt  = '0;
              res.event_res = mrfr_pkg::EV_TOO_LONG;
            end else if (exp_new != 9'd0 && cnt_new == exp_new) begin
              rx_count_nxt = '0;
              expected_nxt = '0;
              // crc over all bytes but the last two, low byte first
              if (prev_byte_r == h0_base[7:0] && in_data.rx_byte == h0_base[15:8] &&
                  addr_ok) begin
                held_nxt      = 1'b1;
                held_len_nxt  = cnt_new;
                bank_nxt      = !bank_r;
                res.event_res = mrfr_pkg::EV_ACCEPT;
              end else begin
                res.event_res = mrfr_pkg::EV_REJECT;
              end
            end
          end
        end
        mrfr_pkg::REQ_READ: begin
          if (held_r && {1'b0, in_data.read_index} < held_len_r) begin
            rd_hit        = 1'b1;
            res.event_res = mrfr_pkg::EV_DONE;
          end
        end
        mrfr_pkg::REQ_RELEASE: begin
          if (held_r) begin
            held_nxt      = 1'b0;
            held_len_nxt  = '0;
            res.event_res = mrfr_pkg::EV_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    res.frame_ready  = held_nxt;
    res.frame_length = held_nxt ? held_len_nxt : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= 8'd1;
      gap_timeout_r <= 16'd4;
      rx_count_r    <= '0;
      expected_r    <= '0;
      last_time_r   <= '0;
      bank_r        <= 1'b0;
      held_r        <= 1'b0;
      held_len_r    <= '0;
      crc_run_r     <= mrfr_pkg::CRC_INIT;
      crc_h0_r      <= mrfr_pkg::CRC_INIT;
      crc_h1_r      <= mrfr_pkg::CRC_INIT;
      hdr0_r        <= '0;
      hdr1_r        <= '0;
      prev_byte_r   <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrfr_pkg::REG_SLAVE_ADDR:  slave_addr_r  <= cfg_wdata[7:0];
          mrfr_pkg::REG_GAP_TIMEOUT: gap_timeout_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      rx_count_r  <= rx_count_nxt;
      expected_r  <= expected_nxt;
      last_time_r <= last_time_nxt;
      bank_r      <= bank_nxt;
      held_r      <= held_nxt;
      held_len_r  <= held_len_nxt;
      crc_run_r   <= crc_run_nxt;
      crc_h0_r    <= crc_h0_nxt;
      crc_h1_r    <= crc_h1_nxt;
      hdr0_r      <= hdr0_nxt;
      hdr1_r      <= hdr1_nxt;
      prev_byte_r <= prev_byte_nxt;
      s1_valid_r  <= accept;
    end
  end

  // result payload and frame store
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r    <= res;
      s1_rd_hit_r <= rd_hit;
    end
    if (wr_en) begin
      store[wr_addr] <= in_data.rx_byte;
    end
    store_q_r <= store[rd_addr];
  end

  always_comb begin
    q_push                = s1_valid_r;
    q_entry.res           = s1_res_r;
    q_entry.res.read_data = store_q_r;
    q_entry.rd_hit        = s1_rd_hit_r;
  end

  a_held_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (held_len_r >= mrfr_pkg::LEN_FIXED && held_len_r <= FRAME_MAX_C))
    else $error("held frame length out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= FRAME_MAX_C)
    else $error("receive count beyond frame limit");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_r) |-> (bank_r != $past(bank_r)))
    else $error("frame held without switching receive bank");

  a_no_write_held: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> !wr_en)
    else $error("store written while a frame is held");

endmodule

// File: hdl/mrfr_queue.sv
// short result queue between front and back
module mrfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  mrfr_pkg::mrfr_entry_t  push_entry,
  output mrfr_pkg::mrfr_q_room_t room,
  input  logic                   pop,
  output logic                   pop_valid,
  output mrfr_pkg::mrfr_entry_t  pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  mrfr_pkg::mrfr_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign do_pop        = pop && pop_valid;
  assign pop_valid     = count_r != '0;
  assign pop_entry     = slots[rd_ptr_r];
  assign room.room_one = count_r < CNT_W'(DEPTH);
  assign room.room_two = count_r < CNT_W'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (room.room_one || do_pop))
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: hdl/mrfr_back.sv
// back end: output register that drives the result channel
module mrfr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  mrfr_pkg::mrfr_entry_t pop_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mrfr_pkg::mrfr_out_t   out_data
);

  logic                out_valid_r;
  mrfr_pkg::mrfr_out_t out_data_r;
  mrfr_pkg::mrfr_out_t word_nxt;

  assign pop = pop_valid && (!out_valid_r || !out_stall);

  // read data only shows on a read that hit the held frame
  always_comb begin
    word_nxt           = pop_entry.res;
    word_nxt.read_data = pop_entry.rd_hit ? pop_entry.res.read_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/modbus_rtu_frame_receiver_unit.sv
// top level of the modbus rtu request frame receiver
// Modbus RTU slave frame receiver. Each input word is a received byte with its
// millisecond tick, a read of one byte of the held frame, or a release of that
// frame; each word gives exactly one result word, in order. A new word can be
// taken every clock cycle while in_stall is low; a result passes the front's
// result register with the frame store read, the queue and the output register
// to the result port, plus any time the result side stalls. A four-entry queue
// and an output register sit between the two sides, so the input keeps taking
// words while a finished result waits, until the queue is nearly full. The
// frame store has two banks of FRAME_MAX bytes: one keeps the held frame, the
// other fills after release; bytes arriving while a frame is held are dropped.
// The store needs no clearing after reset; only written bytes are ever read
// back. Configuration (slave address, gap timeout) is written through a plain
// write port, only while idle: a rule for the user, not enforced by the block.
module modbus_rtu_frame_receiver_unit #(
  parameter int FRAME_MAX   = 256,  // largest frame, 16 to 256
  parameter int QUEUE_DEPTH = 4     // result queue depth, at least 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mrfr_pkg::mrfr_in_t              in_data,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output mrfr_pkg::mrfr_out_t             out_data,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mrfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // front to queue
  mrfr_pkg::mrfr_q_room_t q_room;
  logic                   q_push;
  mrfr_pkg::mrfr_entry_t  q_entry;

  // queue to back
  logic                   q_pop;
  logic                   q_valid;
  mrfr_pkg::mrfr_entry_t  q_head;

  // frame state, crc, frame store and result staging
  mrfr_front #(
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_room    (q_room),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // decouples the front from output stalls
  mrfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .room       (q_room),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_head)
  );

  // output register on the result channel
  mrfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_entry (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
